>>> design/jsu_pkg.sv
// Shared types and codes for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

  // Front-end phases
  localparam logic [2:0] PH_TEXT    = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_HEX1    = 3'd2;
  localparam logic [2:0] PH_WAIT_BS = 3'd3;
  localparam logic [2:0] PH_WAIT_U  = 3'd4;
  localparam logic [2:0] PH_HEX2    = 3'd5;
  localparam logic [2:0] PH_UTF8    = 3'd6;

  // Result status codes
  localparam logic [3:0] ST_DATA       = 4'd0;
  localparam logic [3:0] ST_CLOSED     = 4'd1;
  localparam logic [3:0] ST_CTRL       = 4'd2;
  localparam logic [3:0] ST_BAD_ESC    = 4'd3;
  localparam logic [3:0] ST_BAD_HEX    = 4'd4;
  localparam logic [3:0] ST_MISS_LOW   = 4'd5;
  localparam logic [3:0] ST_BAD_LOW    = 4'd6;
  localparam logic [3:0] ST_STRAY_LOW  = 4'd7;
  localparam logic [3:0] ST_BAD_UTF8   = 4'd8;
  localparam logic [3:0] ST_SHORT_UTF8 = 4'd9;
  localparam logic [3:0] ST_UNTERM     = 4'd10;
  localparam logic [3:0] ST_OPEN_ESC   = 4'd11;
  localparam logic [3:0] ST_SHORT_UNI  = 4'd12;

  // Configuration register indexes
  localparam logic REG_VALIDATE = 1'b0;

  // Results caused by one input byte: up to four data bytes, then an
  // optional status item.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            has_tail;
    logic [3:0]      tail;
  } jsu_job_t;

endpackage
`default_nettype wire

>>> design/jsu_front.sv
// Front end: per-byte string state machine that builds at most one job per accepted byte.
`default_nettype none
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       input_ends,
  input  wire logic       validate_utf8,
  input  wire logic       q_full,
  output logic            push,
  output jsu_job_t        job
);

  logic [2:0]      phase, phase_next;
  logic [15:0]     code_accum, code_accum_next;
  logic [9:0]      high_half, high_half_next;
  logic [1:0]      hex_count, hex_count_next;
  logic [2:0][7:0] utf8_hold, utf8_hold_next;
  logic [1:0]      utf8_need, utf8_need_next;
  logic [1:0]      utf8_have, utf8_have_next;

  logic            accept;
  logic [3:0]      err;
  logic            done;
  logic [4:0]      hv;
  logic [15:0]     acc_new;
  logic [20:0]     cp;
  logic [7:0]      esc_char;
  logic [7:0]      lead;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (l >= 8'h61 && l <= 8'h66) return {1'b1, 4'(l - 8'h57)};
    return 5'd0;
  endfunction

  // UTF-8 encoding of a code point: bytes and count
  function automatic logic [34:0] encode(input logic [20:0] c);
    logic [3:0][7:0] o;
    logic [2:0]      n;
    o = '0;
    if (c <= 21'h7f) begin
      o[0] = c[7:0];
      n = 3'd1;
    end else if (c <= 21'h7ff) begin
      o[0] = {3'b110, c[10:6]};
      o[1] = {2'b10, c[5:0]};
      n = 3'd2;
    end else if (c <= 21'hffff) begin
      o[0] = {4'b1110, c[15:12]};
      o[1] = {2'b10, c[11:6]};
      o[2] = {2'b10, c[5:0]};
      n = 3'd3;
    end else begin
      o[0] = {5'b11110, c[20:18]};
      o[1] = {2'b10, c[17:12]};
      o[2] = {2'b10, c[11:6]};
      o[3] = {2'b10, c[5:0]};
      n = 3'd4;
    end
    return {o, n};
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hv       = hex_value(in_byte);
  assign acc_new  = {code_accum[11:0], hv[3:0]};
  assign lead     = utf8_hold[0];

  always_comb begin
    unique case (in_byte)
      8'h22:   esc_char = 8'h22;
      8'h5c:   esc_char = 8'h5c;
      8'h2f:   esc_char = 8'h2f;
      8'h62:   esc_char = 8'h08;
      8'h66:   esc_char = 8'h0c;
      8'h6e:   esc_char = 8'h0a;
      8'h72:   esc_char = 8'h0d;
      8'h74:   esc_char = 8'h09;
      default: esc_char = 8'h00;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    code_accum_next = code_accum;
    high_half_next  = high_half;
    hex_count_next  = hex_count;
    utf8_hold_next  = utf8_hold;
    utf8_need_next  = utf8_need;
    utf8_have_next  = utf8_have;
    job             = '0;
    err             = ST_DATA;
    done            = 1'b0;
    cp              = 21'(acc_new);

    unique case (phase)
      PH_TEXT: begin
        if (in_byte == 8'h22) begin
          job.has_tail = 1'b1;
          job.tail     = ST_CLOSED;
          done         = 1'b1;
        end else if (in_byte == 8'h5c) begin
          phase_next = PH_ESC;
        end else if (in_byte < 8'h20) begin
          err = ST_CTRL;
        end else if (!validate_utf8 || in_byte < 8'h80) begin
          job.bytes[0] = in_byte;
          job.nbytes   = 3'd1;
        end else begin
          if (in_byte >= 8'hc2 && in_byte <= 8'hdf) utf8_need_next = 2'd1;
          else if (in_byte >= 8'he0 && in_byte <= 8'hef) utf8_need_next = 2'd2;
          else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) utf8_need_next = 2'd3;
          else err = ST_BAD_UTF8;
          utf8_hold_next[0] = in_byte;
          utf8_have_next    = 2'd0;
          phase_next        = PH_UTF8;
        end
      end
      PH_ESC: begin
        if (in_byte == 8'h75) begin
          phase_next      = PH_HEX1;
          hex_count_next  = 2'd0;
          code_accum_next = '0;
        end else if (esc_char == 8'h00) begin
          err = ST_BAD_ESC;
        end else begin
          job.bytes[0] = esc_char;
          job.nbytes   = 3'd1;
          phase_next   = PH_TEXT;
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (!hv[4]) begin
          err = ST_BAD_HEX;
        end else if (hex_count != 2'd3) begin
          hex_count_next  = hex_count + 2'd1;
          code_accum_next = acc_new;
        end else begin
          hex_count_next  = 2'd0;
          code_accum_next = '0;
          if (phase == PH_HEX1) begin
            if (acc_new[15:10] == 6'b110110) begin
              high_half_next = acc_new[9:0];
              phase_next     = PH_WAIT_BS;
            end else if (acc_new[15:10] == 6'b110111) begin
              err = ST_STRAY_LOW;
            end else begin
              {job.bytes, job.nbytes} = encode(cp);
              phase_next = PH_TEXT;
            end
          end else begin
            // join the surrogate pair
            cp = 21'h10000 + {1'b0, high_half, acc_new[9:0]};
            if (acc_new[15:10] != 6'b110111) begin
              err = ST_BAD_LOW;
            end else begin
              {job.bytes, job.nbytes} = encode(cp);
              phase_next = PH_TEXT;
            end
          end
        end
      end
      PH_WAIT_BS: begin
        if (in_byte == 8'h5c) phase_next = PH_WAIT_U;
        else err = ST_MISS_LOW;
      end
      PH_WAIT_U: begin
        if (in_byte == 8'h75) begin
          phase_next      = PH_HEX2;
          hex_count_next  = 2'd0;
          code_accum_next = '0;
        end else begin
          err = ST_MISS_LOW;
        end
      end
      default: begin
        // held UTF-8 sequence; first continuation has range limits
        if (utf8_have == 2'd0 &&
            ((lead == 8'he0 && in_byte < 8'ha0) || (lead == 8'hed && in_byte >= 8'ha0) ||
             (lead == 8'hf0 && in_byte < 8'h90) || (lead == 8'hf4 && in_byte >= 8'h90)))
          err = ST_BAD_UTF8;
        if (in_byte[7:6] != 2'b10) err = ST_BAD_UTF8;
        if ({1'b0, utf8_have} + 3'd1 >= {1'b0, utf8_need} || utf8_have >= 2'd2) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) <= utf8_have) job.bytes[i] = utf8_hold[i];
          end
          job.bytes[utf8_have + 2'd1] = in_byte;
          job.nbytes     = {1'b0, utf8_have} + 3'd2;
          utf8_need_next = 2'd0;
          utf8_have_next = 2'd0;
          phase_next     = PH_TEXT;
        end else begin
          utf8_hold_next[utf8_have + 2'd1] = in_byte;
          utf8_have_next = utf8_have + 2'd1;
        end
      end
    endcase

    if (err != ST_DATA) begin
      job          = '0;
      job.has_tail = 1'b1;
      job.tail     = err;
      done         = 1'b1;
    end

    if (input_ends && !done) begin
      job.has_tail = 1'b1;
      unique case (phase_next)
        PH_TEXT:                        job.tail = ST_UNTERM;
        PH_ESC:                         job.tail = ST_OPEN_ESC;
        PH_HEX1:                        job.tail = ST_SHORT_UNI;
        PH_WAIT_BS, PH_WAIT_U, PH_HEX2: job.tail = ST_MISS_LOW;
        default:                        job.tail = ST_SHORT_UTF8;
      endcase
      done = 1'b1;
    end

    if (done) begin
      phase_next      = PH_TEXT;
      code_accum_next = '0;
      high_half_next  = '0;
      hex_count_next  = '0;
      utf8_need_next  = '0;
      utf8_have_next  = '0;
    end
  end

  assign push = accept && (job.nbytes != 3'd0 || job.has_tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TEXT;
      code_accum <= '0;
      high_half  <= '0;
      hex_count  <= '0;
      utf8_need  <= '0;
      utf8_have  <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      code_accum <= code_accum_next;
      high_half  <= high_half_next;
      hex_count  <= hex_count_next;
      utf8_need  <= utf8_need_next;
      utf8_have  <= utf8_have_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) utf8_hold <= utf8_hold_next;
  end

endmodule
`default_nettype wire

>>> design/jsu_queue.sv
// Short job queue between front and back end.
`default_nettype none
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  jsu_job_t      push_job,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output jsu_job_t      head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_job_t        entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

>>> design/jsu_back.sv
// Back end: plays out each job one result item per cycle while out_ready is high.
`default_nettype none
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  jsu_job_t        head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [3:0]      status,
  output logic            run_last
);

  jsu_job_t   cur;
  logic       busy;
  logic [2:0] idx;
  logic [2:0] total;
  logic       is_data;

  assign total     = cur.nbytes + {2'b0, cur.has_tail};
  assign is_data   = idx < cur.nbytes;
  assign out_valid = busy;
  assign out_byte  = is_data ? cur.bytes[idx[1:0]] : 8'h00;
  assign status    = is_data ? ST_DATA : cur.tail;
  assign run_last  = (idx == total - 3'd1);
  assign pop       = head_valid && (!busy || (out_ready && run_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (run_last) busy <= 1'b0;
      else idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head_job;
  end

endmodule
`default_nettype wire

>>> design/json_string_unescape.sv
// A result item passes through the job queue and the back end's job register before it appears.
// Throughput: one input byte per cycle while each byte gives at most one result and out_ready
// is high; a byte that gives several results keeps the back end busy until all are played out.
// The job queue (QUEUE_DEPTH entries) absorbs bursts between the two sides.
// Reset (rst, synchronous): idle in plain text, queue empty, validate_utf8 = 0.
`default_nettype none
module json_string_unescape
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        input_ends,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [3:0]       status,
  output logic             run_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic     validate_utf8;
  logic     q_full, push, pop, head_valid;
  jsu_job_t job, head_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VALIDATE) ? {31'b0, validate_utf8} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      validate_utf8 <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_VALIDATE) begin
      validate_utf8 <= pwdata[0];
    end
  end

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .input_ends    (input_ends),
    .validate_utf8 (validate_utf8),
    .q_full        (q_full),
    .push          (push),
    .job           (job)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .status     (status),
    .run_last   (run_last)
  );

endmodule
`default_nettype wire
